/* sv/ofd_pkg.sv */
`timescale 1ns / 1ps

package ofd_pkg;

    localparam logic [7:0]  START_A     = 8'hFE;
    localparam logic [7:0]  START_B     = 8'h0A;
    localparam logic [7:0]  TAIL_OK     = 8'hF5;
    localparam logic [7:0]  QUALITY_OK  = 8'hFF;
    localparam logic [7:0]  QUALITY_BAD = 8'h00;
    localparam logic [13:0] SCALE_RESET = 14'd5325;
    localparam int          SCALE_FRAC  = 12;

    // Register index as seen on paddr[2].
    localparam logic REG_FLOW_SCALE = 1'b0;

    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_SECOND = 4'd1,
        PH_PAY0   = 4'd2,
        PH_PAY1   = 4'd3,
        PH_PAY2   = 4'd4,
        PH_PAY3   = 4'd5,
        PH_PAY4   = 4'd6,
        PH_PAY5   = 4'd7,
        PH_SKIP0  = 4'd8,
        PH_SKIP1  = 4'd9,
        PH_TAIL   = 4'd10
    } phase_t;

    // One complete frame handed from the parser to the arithmetic side.
    typedef struct packed {
        logic [15:0] flow_x_raw;
        logic [15:0] flow_y_raw;
        logic [15:0] span;
        logic [47:0] time_us;
        logic        tail_ok;
    } frame_rec_t;

    // value * scale / 4096, rounded half away from zero. The magnitude is at
    // most 32768, so with a 14-bit scale the result stays inside 18 bits.
    function automatic logic signed [17:0] scale_flow(input logic signed [16:0] value,
                                                      input logic [13:0] scale);
        logic        neg;
        logic [16:0] mag;
        logic [30:0] prod;
        logic [30:0] rounded;
        logic [17:0] res;
        neg     = value[16];
        mag     = neg ? 17'(-value) : 17'(value);
        prod    = 31'(mag) * 31'(scale);
        rounded = prod + 31'(1 << (SCALE_FRAC - 1));
        res     = rounded[SCALE_FRAC +: 18];
        return neg ? $signed(18'(-res)) : $signed(res);
    endfunction

endpackage

/* sv/ofd_front.sv */
`timescale 1ns / 1ps

module ofd_front #(
    parameter int TIME_WIDTH = 48
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               beat_acc,
    input  logic [7:0]         rx_byte,
    input  logic [47:0]        now_us,
    output logic               push,
    output ofd_pkg::frame_rec_t rec
);
    import ofd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  payload_reg [6];
    logic [2:0]  pay_idx;
    logic        pay_wr;
    logic [63:0] now_wide;
    logic [63:0] time_mask;
    logic [63:0] now_masked;

    assign pay_idx = 3'(phase_reg - PH_PAY0);
    assign pay_wr  = beat_acc && (phase_reg >= PH_PAY0) && (phase_reg <= PH_PAY5);

    assign now_wide   = 64'(now_us);
    assign time_mask  = ~64'd0 >> (64 - TIME_WIDTH);
    assign now_masked = now_wide & time_mask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pay_wr) begin
            payload_reg[pay_idx] <= rx_byte;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        push       = 1'b0;
        case (phase_reg)
            PH_SECOND: begin
                // A bad second byte drops back to hunting without being
                // looked at again as a start byte.
                if (beat_acc) phase_next = (rx_byte == START_B) ? PH_PAY0 : PH_HUNT;
            end
            PH_PAY0, PH_PAY1, PH_PAY2, PH_PAY3, PH_PAY4, PH_PAY5, PH_SKIP0: begin
                if (beat_acc) phase_next = phase_t'(phase_reg + 4'd1);
            end
            PH_SKIP1: begin
                if (beat_acc) phase_next = PH_TAIL;
            end
            PH_TAIL: begin
                if (beat_acc) begin
                    phase_next = PH_HUNT;
                    push       = 1'b1;
                end
            end
            default: begin
                if (beat_acc) phase_next = (rx_byte == START_A) ? PH_SECOND : PH_HUNT;
            end
        endcase
    end

    assign rec.flow_x_raw = {payload_reg[1], payload_reg[0]};
    assign rec.flow_y_raw = {payload_reg[3], payload_reg[2]};
    assign rec.span       = {payload_reg[5], payload_reg[4]};
    assign rec.time_us    = now_masked[47:0];
    assign rec.tail_ok    = (rx_byte == TAIL_OK);

endmodule

/* sv/ofd_fifo.sv */
`timescale 1ns / 1ps

module ofd_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ofd_pkg::frame_rec_t push_rec,
    input  logic                pop,
    output logic                not_empty,
    output logic                full,
    output ofd_pkg::frame_rec_t pop_rec
);
    import ofd_pkg::*;

    frame_rec_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop_rec   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

/* sv/ofd_back.sv */
`timescale 1ns / 1ps

module ofd_back #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rec_valid,
    input  ofd_pkg::frame_rec_t rec,
    input  logic [13:0]         flow_scale,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [17:0]  flow_x_integral,
    output logic signed [17:0]  flow_y_integral,
    output logic [15:0]         sensor_span_us,
    output logic [31:0]         frame_interval_us,
    output logic [47:0]         frame_time_us,
    output logic [7:0]          quality
);
    import ofd_pkg::*;

    logic                  out_valid_reg;
    logic signed [17:0]    fx_reg, fy_reg;
    logic [15:0]           span_reg;
    logic [31:0]           interval_reg;
    logic [47:0]           time_reg;
    logic [7:0]            quality_reg;
    logic [TIME_WIDTH-1:0] last_time_reg;

    logic signed [16:0]    raw_x, raw_y, neg_y;
    logic [63:0]           now_wide;
    logic [TIME_WIDTH-1:0] now_tw, diff_tw;
    logic [63:0]           diff_wide;
    logic [31:0]           interval_next;

    assign pop = rec_valid && (!out_valid_reg || out_ready);

    assign raw_x = 17'($signed(rec.flow_x_raw));
    assign raw_y = 17'($signed(rec.flow_y_raw));
    assign neg_y = -raw_y;

    // Time difference wraps at the configured time width.
    assign now_wide      = 64'(rec.time_us);
    assign now_tw        = now_wide[TIME_WIDTH-1:0];
    assign diff_tw       = now_tw - last_time_reg;
    assign diff_wide     = 64'(diff_tw);
    assign interval_next = (|diff_wide[63:32]) ? 32'hFFFF_FFFF : diff_wide[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            last_time_reg <= '0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
            last_time_reg <= now_tw;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            fx_reg       <= scale_flow(neg_y, flow_scale);
            fy_reg       <= scale_flow(raw_x, flow_scale);
            span_reg     <= rec.span;
            interval_reg <= interval_next;
            time_reg     <= rec.time_us;
            quality_reg  <= rec.tail_ok ? QUALITY_OK : QUALITY_BAD;
        end
    end

    assign out_valid         = out_valid_reg;
    assign flow_x_integral   = fx_reg;
    assign flow_y_integral   = fy_reg;
    assign sensor_span_us    = span_reg;
    assign frame_interval_us = interval_reg;
    assign frame_time_us     = time_reg;
    assign quality           = quality_reg;

endmodule

/* sv/optical_flow_frame_decoder_unit.sv */
`timescale 1ns / 1ps
// After its tail beat is accepted, a frame is written to the queue, then to the output register once m_* is free.
// Throughput: one input beat per cycle while s_tready is high; the parser state register takes each accepted byte.
// A two-entry frame queue and the output register decouple the parser from m_tready;
// s_tready drops only while two finished frames wait behind a stalled output.
// Reset (aresetn, synchronous, active low) returns the parser to hunting, empties the
// queue and output, clears the last frame time and sets flow_scale to 5325.

module optical_flow_frame_decoder_unit #(
    parameter int TIME_WIDTH = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,  // rx_byte[7:0], now_us[55:8]
    output logic         m_tvalid,
    input  logic         m_tready,
    // flow_x_integral[17:0], flow_y_integral[35:18], sensor_span_us[51:36],
    // frame_interval_us[83:52], frame_time_us[131:84], quality[139:132], zero[143:140]
    output logic [143:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ofd_pkg::*;

    logic              beat_acc;
    logic              push, pop, rec_valid, fifo_full;
    frame_rec_t        push_rec, pop_rec;
    logic [13:0]       scale_reg;
    logic              cfg_wr;
    logic signed [17:0] flow_x, flow_y;
    logic [15:0]       span;
    logic [31:0]       interval;
    logic [47:0]       ftime;
    logic [7:0]        qual;

    assign beat_acc = s_tvalid && s_tready;
    assign s_tready = !fifo_full;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FLOW_SCALE);
    assign prdata = (paddr[2] == REG_FLOW_SCALE) ? 32'(scale_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
        end else if (cfg_wr) begin
            scale_reg <= pwdata[13:0];
        end
    end

    ofd_front #(.TIME_WIDTH(TIME_WIDTH)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .beat_acc (beat_acc),
        .rx_byte  (s_tdata[7:0]),
        .now_us   (s_tdata[55:8]),
        .push     (push),
        .rec      (push_rec)
    );

    ofd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .not_empty (rec_valid),
        .full      (fifo_full),
        .pop_rec   (pop_rec)
    );

    ofd_back #(.TIME_WIDTH(TIME_WIDTH)) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .rec_valid         (rec_valid),
        .rec               (pop_rec),
        .flow_scale        (scale_reg),
        .pop               (pop),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .flow_x_integral   (flow_x),
        .flow_y_integral   (flow_y),
        .sensor_span_us    (span),
        .frame_interval_us (interval),
        .frame_time_us     (ftime),
        .quality           (qual)
    );

    assign m_tdata = {4'd0, qual, ftime, interval, span, flow_y, flow_x};

endmodule

/* sv/ofd_checker.sv */
`timescale 1ns / 1ps

module ofd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic         pready
);

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // No result is pending right after reset.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Quality is a flag carried as all ones or all zeros.
    a_quality: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[139:132] == 8'h00 || m_tdata[139:132] == 8'hFF))
        else $error("quality neither 0 nor 255");

    // The padding above the last field stays zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[143:140] == 4'd0))
        else $error("padding bits set");

    // A result can only be held back by the output; input stalls need a result pending on m_tvalid.
    a_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && pready)
        else $error("input stalled while output idle");

endmodule

bind optical_flow_frame_decoder_unit ofd_checker u_ofd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
